### rtl/msbfb_pkg.sv
// request and status codes for the multi-slot byte fifo bank
// used by the top level and by its port checker; depends on nothing
`default_nettype none

package msbfb_pkg;

  // request kinds carried on req_type; unknown codes behave as a stat
  typedef enum logic [2:0] {
    REQ_CREATE = 3'd0,
    REQ_CLOSE  = 3'd1,
    REQ_WRITE  = 3'd2,
    REQ_READ   = 3'd3,
    REQ_STAT   = 3'd4,
    REQ_COUNT  = 3'd5
  } req_type_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFREE   = 3'd1,
    ST_NOTALLOC = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

`default_nettype wire

### rtl/multi_slot_byte_fifo_bank.sv
// top level: bank of byte ring buffers with slot allocation
// depends on msbfb_pkg for request and status codes
`default_nettype none

// One request is taken per clock (busy is never raised) and answers with one
// result beat, marked by done, on the cycle right after it was accepted. All
// result fields are registered, as is the read data of the byte store;
// slot state, pointers and the lowest-free-slot encoder settle in the same
// cycle as the request, so back-to-back requests to one slot see each other's
// effects. The byte store needs no clearing pass after reset: a read only
// returns bytes that were written. Results cannot be stalled.
module multi_slot_byte_fifo_bank #(
  parameter int SLOTS   = 8,
  parameter int BUF_LEN = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] req_type,
  input  wire logic [2:0] slot,
  input  wire logic [7:0] data_in,
  output logic            done,
  output logic [2:0]      status,
  output logic [2:0]      slot_out,
  output logic [7:0]      data_out,
  output logic            allocated,
  output logic [8:0]      fill_level,
  output logic [3:0]      used_count
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW    = $clog2(BUF_LEN + 1);
  localparam int PW    = $clog2(BUF_LEN);
  localparam int UW    = $clog2(SLOTS + 1);
  localparam int DEPTH = SLOTS * BUF_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // wide enough to hold both the slot field and the slot count itself
  localparam int CW    = ((SW > 3) ? SW : 3) + 1;

  // per-slot state
  logic          slot_valid [SLOTS];
  logic [LW-1:0] level      [SLOTS];
  logic [PW-1:0] rd_ptr     [SLOTS];
  logic [PW-1:0] wr_ptr     [SLOTS];
  logic [UW-1:0] in_use;

  // byte store and its registered read port
  logic [7:0]    byte_store [DEPTH];
  logic [7:0]    rd_data;

  // request decode
  logic          accept;
  logic          is_create, is_close, is_write, is_read, is_count;
  logic          req_inr;
  logic [SW-1:0] req_idx;
  logic          found;
  logic [SW-1:0] free_idx;
  logic [SW-1:0] tgt;
  logic          tgt_inr;
  logic          tgt_valid;
  logic [LW-1:0] tgt_level;
  logic [PW-1:0] tgt_rd_ptr, tgt_wr_ptr;
  logic          create_ok, close_ok, write_ok, read_ok;
  logic [PW-1:0] ptr_sel, ptr_inc;
  logic [AW-1:0] mem_addr;
  logic [2:0]    status_next;
  logic          alloc_next;
  logic [LW-1:0] level_next;
  logic [UW-1:0] in_use_next;
  logic          read_ok_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_create = (req_type == msbfb_pkg::REQ_CREATE);
  assign is_close  = (req_type == msbfb_pkg::REQ_CLOSE);
  assign is_write  = (req_type == msbfb_pkg::REQ_WRITE);
  assign is_read   = (req_type == msbfb_pkg::REQ_READ);
  assign is_count  = (req_type == msbfb_pkg::REQ_COUNT);

  assign req_inr = (CW'(slot) < CW'(SLOTS));
  assign req_idx = SW'(slot);

  // lowest free slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        found    = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // the one slot this request looks at
  assign tgt        = is_create ? free_idx : req_idx;
  assign tgt_inr    = is_create ? found : req_inr;
  assign tgt_valid  = slot_valid[tgt];
  assign tgt_level  = level[tgt];
  assign tgt_rd_ptr = rd_ptr[tgt];
  assign tgt_wr_ptr = wr_ptr[tgt];

  assign create_ok = is_create && found;
  assign close_ok  = is_close && req_inr && tgt_valid;
  assign write_ok  = is_write && req_inr && tgt_valid && (tgt_level != LW'(BUF_LEN));
  assign read_ok   = is_read && req_inr && (tgt_level != '0);

  // ring pointer advance and flat store address
  assign ptr_sel  = write_ok ? tgt_wr_ptr : tgt_rd_ptr;
  assign ptr_inc  = ((PW+1)'(ptr_sel) + (PW+1)'(1) == (PW+1)'(BUF_LEN)) ? '0
                    : ptr_sel + PW'(1);
  assign mem_addr = AW'(AW'(tgt) * AW'(BUF_LEN) + AW'(ptr_sel));

  // status and post-request view of the target slot
  always_comb begin
    status_next = msbfb_pkg::ST_OK;
    if (is_create) begin
      if (!found) status_next = msbfb_pkg::ST_NOFREE;
    end else if (is_count) begin
      status_next = msbfb_pkg::ST_OK;
    end else if (!req_inr) begin
      status_next = msbfb_pkg::ST_NOTALLOC;
    end else if (is_write) begin
      if (!tgt_valid)                        status_next = msbfb_pkg::ST_NOTALLOC;
      else if (tgt_level == LW'(BUF_LEN))    status_next = msbfb_pkg::ST_FULL;
    end else if (is_read) begin
      if (tgt_level == '0) status_next = msbfb_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    alloc_next  = tgt_valid;
    level_next  = tgt_level;
    in_use_next = in_use;
    if (create_ok) begin
      alloc_next  = 1'b1;
      in_use_next = in_use + UW'(1);
    end
    if (close_ok) begin
      alloc_next  = 1'b0;
      in_use_next = in_use - UW'(1);
    end
    if (write_ok) level_next = tgt_level + LW'(1);
    if (read_ok)  level_next = tgt_level - LW'(1);
  end

  // slot state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        level[i]      <= '0;
        rd_ptr[i]     <= '0;
        wr_ptr[i]     <= '0;
      end
      in_use <= '0;
    end else if (accept) begin
      if (tgt_inr) begin
        slot_valid[tgt] <= alloc_next;
        level[tgt]      <= level_next;
      end
      if (write_ok) wr_ptr[tgt] <= ptr_inc;
      if (read_ok)  rd_ptr[tgt] <= ptr_inc;
      in_use <= in_use_next;
    end
  end

  // byte store: one write or one read per request
  always_ff @(posedge clk) begin
    if (accept && write_ok) byte_store[mem_addr] <= data_in;
    if (accept && read_ok)  rd_data <= byte_store[mem_addr];
  end

  // result beat strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      slot_out   <= is_create ? (found ? 3'(free_idx) : 3'd0) : slot;
      allocated  <= tgt_inr && alloc_next;
      fill_level <= tgt_inr ? 9'(level_next) : 9'd0;
      used_count <= 4'(in_use_next);
      read_ok_q  <= read_ok;
    end
  end

  assign data_out = read_ok_q ? rd_data : 8'd0;

endmodule

`default_nettype wire

### rtl/msbfb_checker.sv
// port-level checker for the multi-slot byte fifo bank, with its bind
// depends on msbfb_pkg for request and status codes
`default_nettype none

module msbfb_checker #(
  parameter int SLOTS = 8
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] req_type,
  input wire logic       done,
  input wire logic [2:0] status,
  input wire logic [7:0] data_out,
  input wire logic       allocated,
  input wire logic [8:0] fill_level,
  input wire logic [3:0] used_count
);

  // exactly one result beat per accepted request, in the cycle after it
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (done == $past(start && !busy)))
    else $error("result beat does not match accepted request");

  // slot usage never passes the bank size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(used_count) <= SLOTS))
    else $error("used count above slot count");

  // no free slot only when every slot is taken, with an empty report
  a_nofree: assert property (@(posedge clk) disable iff (rst)
    (done && status == msbfb_pkg::ST_NOFREE) |->
      (32'(used_count) == SLOTS && !allocated && fill_level == 9'd0))
    else $error("no-free report while slots remain");

  // a successful create reports its slot as allocated
  a_create_alloc: assert property (@(posedge clk) disable iff (rst)
    (done && status == msbfb_pkg::ST_OK && $past(req_type) == msbfb_pkg::REQ_CREATE)
      |-> allocated)
    else $error("created slot not shown allocated");

  // returned data appears only on a successful read
  a_data_read: assert property (@(posedge clk) disable iff (rst)
    (done && data_out != 8'd0) |->
      ($past(req_type) == msbfb_pkg::REQ_READ && status == msbfb_pkg::ST_OK))
    else $error("data returned outside a successful read");

endmodule

bind multi_slot_byte_fifo_bank msbfb_checker #(.SLOTS(SLOTS)) u_msbfb_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .req_type   (req_type),
  .done       (done),
  .status     (status),
  .data_out   (data_out),
  .allocated  (allocated),
  .fill_level (fill_level),
  .used_count (used_count)
);

`default_nettype wire
